// ===== rtl/assert_macros.svh =====
// shared assertion macros, clocked on clk with arst_n as the disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold in the same cycle as its trigger
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// property that must hold in the cycle after its trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_NOW(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/bmp4_pkg.sv =====
`timescale 1ns / 1ps

package bmp4_pkg;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SKIP   = 2'd1,
		PH_DATA   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_PIXEL     = 2'd0,
		ST_BAD_SIG   = 2'd1,
		ST_BAD_DEPTH = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [2:0]         color;
		status_t            status;
		logic               last;
	} result_t;

	// configuration register indexes
	localparam logic [1:0] CFG_ORIGIN_X  = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y  = 2'd1;
	localparam logic [1:0] CFG_OVERRIDE  = 2'd2;

	// header byte positions where a field is complete
	localparam logic [31:0] POS_SIG    = 32'd1;
	localparam logic [31:0] POS_OFFSET = 32'd13;
	localparam logic [31:0] POS_WIDTH  = 32'd21;
	localparam logic [31:0] POS_HEIGHT = 32'd25;
	localparam logic [31:0] POS_DEPTH  = 32'd29;

	localparam logic [15:0] SIGNATURE   = 16'h4D42;
	localparam logic [15:0] DEPTH_4BPP  = 16'd4;
	localparam logic [31:0] MIN_OFFSET  = 32'd30;
	localparam logic [3:0]  MAX_COLOR   = 4'd6;
	localparam logic [3:0]  NO_OVERRIDE = 4'd7;
	localparam logic [3:0]  WHITE       = 4'd1;
	localparam logic [2:0]  RES_N0      = 3'd0;

endpackage

// ===== rtl/bmp_4bpp_pixel_decoder.sv =====
`timescale 1ns / 1ps
// channel   dir   handshake            payload
// in        in    in_valid/in_stall    file_byte, start_of_file
// out       out   out_valid/out_stall  pixel_x, pixel_y, pixel_color, status, last_of_run
// cfg       in    cfg_we               cfg_index, cfg_data
//
// one byte is registered, then decoded in the next cycle into zero, one or two results
// that go into a two-entry output buffer; the single result port sets the rate: a data
// byte with two pixels stalls the input until the buffer has room for both results.
// arst_n clears the parser so the first byte after reset is byte 0 of a file.
// out_stall holds the buffer; the input register keeps accepting as long as the buffer
// has room for the results of the byte it holds.
`include "assert_macros.svh"

module bmp_4bpp_pixel_decoder #(
	parameter int MAX_DIM = 4096
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         file_byte,
	input  logic               start_of_file,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [2:0]         pixel_color,
	output logic [1:0]         status,
	output logic               last_of_run
);

	localparam int DIM_W    = $clog2(MAX_DIM + 1);
	localparam int W7_W     = DIM_W + 3;
	localparam int ROWB_MAX = ((MAX_DIM + 7) / 8) * 4;
	localparam int BIR_W    = $clog2(ROWB_MAX + 1);
	localparam int COL_W    = BIR_W + 1;
	localparam int CMP_W    = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;

	function automatic logic [2:0] map_color(input logic [3:0] nib, input logic [3:0] ovr);
		logic [3:0] c;
		c = nib;
		if (c > bmp4_pkg::MAX_COLOR) begin
			c = bmp4_pkg::WHITE;
		end
		if (ovr < bmp4_pkg::NO_OVERRIDE && c != bmp4_pkg::WHITE) begin
			c = ovr;
		end
		return c[2:0];
	endfunction

	// configuration
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [3:0]         ovr_color_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;

	// parser state
	bmp4_pkg::phase_t phase_q, phase_d;
	logic [31:0]      byte_pos_q, byte_pos_d;
	logic [31:0]      hdr_shift_q, hdr_shift_d;
	logic [31:0]      data_off_q, data_off_d;
	logic [DIM_W-1:0] img_w_q, img_w_d;
	logic [DIM_W-1:0] img_h_q, img_h_d;
	logic             w_big_q, w_big_d;
	logic             h_big_q, h_big_d;
	logic             bottom_up_q, bottom_up_d;
	logic [BIR_W-1:0] row_byte_q, row_byte_d;
	logic [DIM_W-1:0] file_row_q, file_row_d;

	// state as seen by the held byte, restarted if it carries a start-of-file mark
	bmp4_pkg::phase_t e_phase;
	logic [31:0]      e_pos;
	logic [31:0]      e_shift;
	logic [31:0]      e_off;
	logic [DIM_W-1:0] e_w;
	logic [DIM_W-1:0] e_h;
	logic             e_w_big;
	logic             e_h_big;
	logic             e_bottom_up;
	logic [BIR_W-1:0] e_row_byte;
	logic [DIM_W-1:0] e_file_row;

	// output buffer
	bmp4_pkg::result_t obuf_q [2];
	bmp4_pkg::result_t obuf_d [2];
	logic [1:0]        ocnt_q, ocnt_d;

	logic [31:0]       hs_new;
	logic [31:0]       h_mag;
	logic              in_data;
	logic [W7_W-1:0]   w7;
	logic [BIR_W-1:0]  row_bytes;
	logic [BIR_W-1:0]  row_byte_inc;
	logic [COL_W-1:0]  col;
	logic [CMP_W-1:0]  col_e;
	logic [CMP_W-1:0]  w_e;
	logic [DIM_W-1:0]  srow;
	logic [DIM_W-1:0]  file_row_inc;
	logic              px0_ok;
	logic              px1_ok;
	bmp4_pkg::result_t res0;
	bmp4_pkg::result_t res1;
	logic [1:0]        res_n;
	logic              pop;
	logic [1:0]        base;
	logic [1:0]        room;
	logic              take;

	always_comb begin
		if (sof_s1) begin
			e_phase     = bmp4_pkg::PH_HEADER;
			e_pos       = '0;
			e_shift     = '0;
			e_off       = '0;
			e_w         = '0;
			e_h         = '0;
			e_w_big     = 1'b0;
			e_h_big     = 1'b0;
			e_bottom_up = 1'b1;
			e_row_byte  = '0;
			e_file_row  = '0;
		end else begin
			e_phase     = phase_q;
			e_pos       = byte_pos_q;
			e_shift     = hdr_shift_q;
			e_off       = data_off_q;
			e_w         = img_w_q;
			e_h         = img_h_q;
			e_w_big     = w_big_q;
			e_h_big     = h_big_q;
			e_bottom_up = bottom_up_q;
			e_row_byte  = row_byte_q;
			e_file_row  = file_row_q;
		end
	end

	// shared datapath terms
	always_comb begin
		hs_new       = {byte_s1, e_shift[31:8]};
		h_mag        = hs_new[31] ? (~hs_new + 32'd1) : hs_new;
		in_data      = (e_phase == bmp4_pkg::PH_DATA) ||
		               (e_phase == bmp4_pkg::PH_SKIP && e_pos == e_off);
		w7           = {3'b000, e_w} + W7_W'(7);
		row_bytes    = BIR_W'({w7 >> 3, 2'b00});
		row_byte_inc = e_row_byte + BIR_W'(1);
		col          = {e_row_byte, 1'b0};
		col_e        = CMP_W'(col);
		w_e          = CMP_W'(e_w);
		px0_ok       = col_e < w_e;
		px1_ok       = (col_e + CMP_W'(1)) < w_e;
		srow         = e_bottom_up ? (e_h - DIM_W'(1) - e_file_row) : e_file_row;
		file_row_inc = e_file_row + DIM_W'(1);
	end

	// results of the byte in the input register
	always_comb begin
		res0        = '0;
		res1        = '0;
		res_n       = 2'd0;
		res1.x      = origin_x_q + 16'(col) + 16'd1;
		res1.y      = origin_y_q + 16'(srow);
		res1.color  = map_color(byte_s1[3:0], ovr_color_q);
		res1.status = bmp4_pkg::ST_PIXEL;
		res1.last   = 1'b1;
		if (valid_s1) begin
			case (e_phase)
				bmp4_pkg::PH_HEADER: begin
					if (e_pos == bmp4_pkg::POS_SIG && hs_new[31:16] != bmp4_pkg::SIGNATURE) begin
						res0.status = bmp4_pkg::ST_BAD_SIG;
						res_n       = 2'd1;
					end else if (e_pos == bmp4_pkg::POS_DEPTH) begin
						if (hs_new[31:16] != bmp4_pkg::DEPTH_4BPP) begin
							res0.status = bmp4_pkg::ST_BAD_DEPTH;
							res_n       = 2'd1;
						end else if (e_w_big || e_h_big) begin
							res0.status = bmp4_pkg::ST_TOO_LARGE;
							res_n       = 2'd1;
						end
					end
				end
				bmp4_pkg::PH_SKIP, bmp4_pkg::PH_DATA: begin
					if (in_data && px0_ok) begin
						res0.x      = origin_x_q + 16'(col);
						res0.y      = origin_y_q + 16'(srow);
						res0.color  = map_color(byte_s1[7:4], ovr_color_q);
						res0.status = bmp4_pkg::ST_PIXEL;
						res_n       = px1_ok ? 2'd2 : 2'd1;
					end
				end
				default: begin
					res_n = 2'd0;
				end
			endcase
		end
		res0.last = (res_n == 2'd1);
	end

	// output buffer room and input take
	always_comb begin
		out_valid = ocnt_q != 2'd0;
		pop       = out_valid && !out_stall;
		base      = ocnt_q - {1'b0, pop};
		room      = 2'd2 - base;
		take      = valid_s1 && (res_n <= room);
		in_stall  = valid_s1 && !take;
	end

	always_comb begin
		obuf_d = obuf_q;
		if (pop) begin
			obuf_d[0] = obuf_q[1];
		end
		if (take && res_n != 2'd0) begin
			obuf_d[base[0]] = res0;
		end
		if (take && res_n == 2'd2) begin
			obuf_d[1] = res1;
		end
		ocnt_d = take ? (base + res_n) : base;
	end

	// parser next state
	always_comb begin
		phase_d     = phase_q;
		byte_pos_d  = byte_pos_q;
		hdr_shift_d = hdr_shift_q;
		data_off_d  = data_off_q;
		img_w_d     = img_w_q;
		img_h_d     = img_h_q;
		w_big_d     = w_big_q;
		h_big_d     = h_big_q;
		bottom_up_d = bottom_up_q;
		row_byte_d  = row_byte_q;
		file_row_d  = file_row_q;
		if (take) begin
			phase_d     = e_phase;
			byte_pos_d  = e_pos;
			hdr_shift_d = e_shift;
			data_off_d  = e_off;
			img_w_d     = e_w;
			img_h_d     = e_h;
			w_big_d     = e_w_big;
			h_big_d     = e_h_big;
			bottom_up_d = e_bottom_up;
			row_byte_d  = e_row_byte;
			file_row_d  = e_file_row;
			case (e_phase)
				bmp4_pkg::PH_HEADER: begin
					hdr_shift_d = hs_new;
					byte_pos_d  = e_pos + 32'd1;
					if (res_n != 2'd0) begin
						phase_d = bmp4_pkg::PH_DONE;
					end else if (e_pos == bmp4_pkg::POS_OFFSET) begin
						data_off_d = (hs_new < bmp4_pkg::MIN_OFFSET) ? bmp4_pkg::MIN_OFFSET
						                                              : hs_new;
					end else if (e_pos == bmp4_pkg::POS_WIDTH) begin
						img_w_d = hs_new[DIM_W-1:0];
						w_big_d = hs_new > 32'(MAX_DIM);
					end else if (e_pos == bmp4_pkg::POS_HEIGHT) begin
						bottom_up_d = !hs_new[31];
						img_h_d     = h_mag[DIM_W-1:0];
						h_big_d     = h_mag > 32'(MAX_DIM);
					end else if (e_pos == bmp4_pkg::POS_DEPTH) begin
						// an empty image ends without results
						phase_d = (e_w == '0 || e_h == '0) ? bmp4_pkg::PH_DONE
						                                   : bmp4_pkg::PH_SKIP;
					end
				end
				bmp4_pkg::PH_SKIP, bmp4_pkg::PH_DATA: begin
					byte_pos_d = e_pos + 32'd1;
					if (in_data) begin
						phase_d = bmp4_pkg::PH_DATA;
						if (row_byte_inc >= row_bytes) begin
							row_byte_d = '0;
							file_row_d = file_row_inc;
							if (file_row_inc >= e_h) begin
								phase_d = bmp4_pkg::PH_DONE;
							end
						end else begin
							row_byte_d = row_byte_inc;
						end
					end
				end
				default: begin
					phase_d = e_phase;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			ovr_color_q <= 4'hF;
		end else if (cfg_we) begin
			case (cfg_index)
				bmp4_pkg::CFG_ORIGIN_X: origin_x_q  <= cfg_data;
				bmp4_pkg::CFG_ORIGIN_Y: origin_y_q  <= cfg_data;
				bmp4_pkg::CFG_OVERRIDE: ovr_color_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= file_byte;
			sof_s1  <= start_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= bmp4_pkg::PH_HEADER;
			byte_pos_q  <= '0;
			hdr_shift_q <= '0;
			data_off_q  <= '0;
			img_w_q     <= '0;
			img_h_q     <= '0;
			w_big_q     <= 1'b0;
			h_big_q     <= 1'b0;
			bottom_up_q <= 1'b1;
			row_byte_q  <= '0;
			file_row_q  <= '0;
			ocnt_q      <= 2'd0;
		end else begin
			phase_q     <= phase_d;
			byte_pos_q  <= byte_pos_d;
			hdr_shift_q <= hdr_shift_d;
			data_off_q  <= data_off_d;
			img_w_q     <= img_w_d;
			img_h_q     <= img_h_d;
			w_big_q     <= w_big_d;
			h_big_q     <= h_big_d;
			bottom_up_q <= bottom_up_d;
			row_byte_q  <= row_byte_d;
			file_row_q  <= file_row_d;
			ocnt_q      <= ocnt_d;
		end
	end

	always_ff @(posedge clk) begin
		obuf_q <= obuf_d;
	end

	assign pixel_x     = obuf_q[0].x;
	assign pixel_y     = obuf_q[0].y;
	assign pixel_color = obuf_q[0].color;
	assign status      = obuf_q[0].status;
	assign last_of_run = obuf_q[0].last;

	`ASSERT_NOW(a_cnt_bound, 1'b1, ocnt_q != 2'd3, "output buffer count out of range")
	`ASSERT_NOW(a_pair_whole, out_valid && !last_of_run, ocnt_q == 2'd2,
		"first pixel of a pair shown without its partner")
	`ASSERT_NOW(a_err_last, out_valid && status != bmp4_pkg::ST_PIXEL, last_of_run,
		"error result not marked last")
	`ASSERT_NEXT(a_stall_holds, in_stall, valid_s1 && $stable(byte_s1),
		"stalled input register lost its byte")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_DIM = 4096;
	localparam int ITEMS = 700;
	localparam int SETTLE = 16;
	localparam int CYCLE_LIMIT = 200000;

	class pixel_scoreboard;
		logic [15:0]          org_x;
		logic [15:0]          org_y;
		logic [3:0]           ovr;
		bmp4_pkg::phase_t     ph;
		logic [31:0]          pos;
		logic [31:0]          hdr;
		logic [31:0]          offs;
		logic [31:0]          wid;
		logic [31:0]          hgt;
		logic                 flip;
		logic [31:0]          col_byte;
		logic [31:0]          row;
		bmp4_pkg::result_t    expected_q[$];
		int                   mismatches;
		int                   checked;
		int                   consumed;

		function new();
			org_x = '0;
			org_y = '0;
			ovr = 4'hf;
			mismatches = 0;
			checked = 0;
			consumed = 0;
			restart();
		endfunction

		function void restart();
			ph = bmp4_pkg::PH_HEADER;
			pos = '0;
			hdr = '0;
			offs = '0;
			wid = '0;
			hgt = '0;
			flip = 1'b1;
			col_byte = '0;
			row = '0;
		endfunction

		function void set_register(logic [1:0] idx, logic [15:0] val);
			case (idx)
				bmp4_pkg::CFG_ORIGIN_X: org_x = val;
				bmp4_pkg::CFG_ORIGIN_Y: org_y = val;
				bmp4_pkg::CFG_OVERRIDE: ovr = val[3:0];
				default: ;
			endcase
		endfunction

		function logic [2:0] remap(logic [3:0] nib);
			logic [3:0] c;
			c = (nib > bmp4_pkg::MAX_COLOR) ? bmp4_pkg::WHITE : nib;
			if (ovr < bmp4_pkg::NO_OVERRIDE && c != bmp4_pkg::WHITE)
				c = ovr;
			return c[2:0];
		endfunction

		function void add_result(logic [15:0] x, logic [15:0] y, logic [2:0] c,
				bmp4_pkg::status_t st, logic fin);
			bmp4_pkg::result_t r;
			r.x = x;
			r.y = y;
			r.color = c;
			r.status = st;
			r.last = fin;
			expected_q.push_back(r);
		endfunction

		// one accepted byte: advance the parser and queue what it should produce
		function void note_byte(logic [7:0] b, logic sof);
			logic [31:0] row_bytes;
			logic [31:0] col;
			logic [31:0] srow;
			logic        two;
			if (sof)
				restart();
			if (ph == bmp4_pkg::PH_DONE)
				return;
			consumed++;
			if (ph == bmp4_pkg::PH_HEADER) begin
				hdr = {b, hdr[31:8]};
				case (pos)
					bmp4_pkg::POS_SIG: begin
						if (hdr[31:16] != bmp4_pkg::SIGNATURE) begin
							add_result('0, '0, bmp4_pkg::RES_N0, bmp4_pkg::ST_BAD_SIG, 1'b1);
							ph = bmp4_pkg::PH_DONE;
						end
					end
					bmp4_pkg::POS_OFFSET: begin
						offs = (hdr < bmp4_pkg::MIN_OFFSET) ? bmp4_pkg::MIN_OFFSET : hdr;
					end
					bmp4_pkg::POS_WIDTH: wid = hdr;
					bmp4_pkg::POS_HEIGHT: begin
						flip = !hdr[31];
						hgt = hdr[31] ? (~hdr + 32'd1) : hdr;
					end
					bmp4_pkg::POS_DEPTH: begin
						if (hdr[31:16] != bmp4_pkg::DEPTH_4BPP) begin
							add_result('0, '0, bmp4_pkg::RES_N0, bmp4_pkg::ST_BAD_DEPTH, 1'b1);
							ph = bmp4_pkg::PH_DONE;
						end else if (wid > MAX_DIM || hgt > MAX_DIM) begin
							add_result('0, '0, bmp4_pkg::RES_N0, bmp4_pkg::ST_TOO_LARGE, 1'b1);
							ph = bmp4_pkg::PH_DONE;
						end else if (wid == 0 || hgt == 0) begin
							ph = bmp4_pkg::PH_DONE;
						end else begin
							ph = bmp4_pkg::PH_SKIP;
						end
					end
					default: ;
				endcase
				pos++;
				return;
			end
			if (ph == bmp4_pkg::PH_SKIP) begin
				if (pos != offs) begin
					pos++;
					return;
				end
				ph = bmp4_pkg::PH_DATA;
			end
			row_bytes = ((wid + 32'd7) >> 3) << 2;
			col = col_byte << 1;
			srow = flip ? (hgt - 32'd1 - row) : row;
			two = (col + 32'd1) < wid;
			if (col < wid)
				add_result(org_x + col[15:0], org_y + srow[15:0], remap(b[7:4]),
					bmp4_pkg::ST_PIXEL, !two);
			if (two)
				add_result(org_x + col[15:0] + 16'd1, org_y + srow[15:0], remap(b[3:0]),
					bmp4_pkg::ST_PIXEL, 1'b1);
			col_byte++;
			if (col_byte >= row_bytes) begin
				col_byte = '0;
				row++;
				if (row >= hgt)
					ph = bmp4_pkg::PH_DONE;
			end
			pos++;
		endfunction

		function void check_pixel(logic [15:0] x, logic [15:0] y, logic [2:0] c,
				logic [1:0] st, logic fin);
			bmp4_pkg::result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: x=%0d y=%0d color=%0d status=%0d last=%0d",
						$signed(x), $signed(y), c, st, fin);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.x !== x || want.y !== y || want.color !== c || want.status !== st
					|| want.last !== fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected x=%0d y=%0d color=%0d status=%0d last=%0d,",
						$signed(want.x), $signed(want.y), want.color, want.status, want.last,
						" got x=%0d y=%0d color=%0d status=%0d last=%0d",
						$signed(x), $signed(y), c, st, fin);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         file_byte;
	logic               start_of_file;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	logic [2:0]         pixel_color;
	logic [1:0]         status;
	logic               last_of_run;

	pixel_scoreboard sb;
	logic calm;
	int   cycles;
	int   files_sent;
	int   bytes_sent;

	bmp_4bpp_pixel_decoder #(.MAX_DIM(MAX_DIM)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.file_byte(file_byte),
		.start_of_file(start_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.status(status),
		.last_of_run(last_of_run)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 12);
	end

	// both channels are observed here, input side first
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(file_byte, start_of_file);
			if (out_valid && !out_stall)
				sb.check_pixel(pixel_x, pixel_y, pixel_color, status, last_of_run);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic sof);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		file_byte <= b;
		start_of_file <= sof;
		// hold until the transfer happens
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_file(input logic sof, input logic [15:0] sig, input logic [31:0] off,
			input logic [31:0] w, input logic [31:0] h, input logic [15:0] depth,
			input int hdr_len, input int body);
		logic [7:0] hb [30];
		for (int i = 0; i < 30; i++)
			hb[i] = 8'($urandom);
		{hb[1], hb[0]} = sig;
		{hb[13], hb[12], hb[11], hb[10]} = off;
		{hb[21], hb[20], hb[19], hb[18]} = w;
		{hb[25], hb[24], hb[23], hb[22]} = h;
		{hb[29], hb[28]} = depth;
		files_sent++;
		for (int i = 0; i < hdr_len; i++)
			send_byte(hb[i], (i == 0) ? sof : 1'b0);
		repeat (body)
			send_byte(8'($urandom), 1'b0);
	endtask

	function automatic int body_len(logic [31:0] off, logic [31:0] w, logic [31:0] hmag);
		int skip;
		skip = (off > bmp4_pkg::MIN_OFFSET) ? int'(off - bmp4_pkg::MIN_OFFSET) : 0;
		return skip + int'((((w + 32'd7) >> 3) << 2) * hmag);
	endfunction

	// sender pauses until every expected pixel has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic reconfigure(input logic [15:0] ox, input logic [15:0] oy,
			input logic [3:0] ov);
		drain_results();
		write_reg(bmp4_pkg::CFG_ORIGIN_X, ox);
		write_reg(bmp4_pkg::CFG_ORIGIN_Y, oy);
		write_reg(bmp4_pkg::CFG_OVERRIDE, {12'd0, ov});
	endtask

	initial begin
		int          kind;
		int          nfile;
		logic [31:0] w;
		logic [31:0] hmag;
		logic [31:0] h;
		logic [31:0] off;
		logic [15:0] sig;
		logic [15:0] depth;
		int          hdr_len;
		int          body;

		sb = new();
		calm = 1'b0;
		files_sent = 0;
		bytes_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		file_byte = '0;
		start_of_file = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(bmp4_pkg::CFG_ORIGIN_X, 16'h7ffe);
		write_reg(bmp4_pkg::CFG_ORIGIN_Y, 16'h8000);
		write_reg(bmp4_pkg::CFG_OVERRIDE, 16'd15);

		// first file carries no start mark, small offset, odd width, bottom-up
		send_file(1'b0, bmp4_pkg::SIGNATURE, 32'd0, 32'd3, 32'd2, bmp4_pkg::DEPTH_4BPP, 30,
			body_len(0, 3, 2));
		send_file(1'b1, 16'h4d43, 32'd30, 32'd2, 32'd2, bmp4_pkg::DEPTH_4BPP, 30, 3);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd2, 32'd2, 16'd8, 30, 2);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd4097, 32'd2, bmp4_pkg::DEPTH_4BPP,
			30, 2);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'hffff_ffff, 32'd1,
			bmp4_pkg::DEPTH_4BPP, 30, 1);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd5, 32'hffff_efff,
			bmp4_pkg::DEPTH_4BPP, 30, 1);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd0, 32'd3, bmp4_pkg::DEPTH_4BPP, 30, 4);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd3, 32'd0, bmp4_pkg::DEPTH_4BPP, 30, 4);
		// no idling on either side for the next three files
		calm = 1'b1;
		// largest accepted size, cut short by the next start mark
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd4096, 32'hffff_f000,
			bmp4_pkg::DEPTH_4BPP, 30, 40);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd34, 32'd2, 32'hffff_fffe,
			bmp4_pkg::DEPTH_4BPP, 30, body_len(34, 2, 2));
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'hffff_fff0, 32'd1, 32'd1,
			bmp4_pkg::DEPTH_4BPP, 30, 10);
		calm = 1'b0;

		reconfigure(16'h8000, 16'h7fff, 4'd0);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd9, 32'd2, bmp4_pkg::DEPTH_4BPP, 30,
			body_len(30, 9, 2));
		reconfigure(16'h7fff, 16'hffff, 4'd6);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd31, 32'd5, 32'd3, bmp4_pkg::DEPTH_4BPP, 30,
			body_len(31, 5, 3));
		reconfigure(16'h0000, 16'h0000, 4'd7);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd29, 32'd8, 32'hffff_ffff,
			bmp4_pkg::DEPTH_4BPP, 30, body_len(30, 8, 1) + 2);
		reconfigure(16'd100, 16'hfff0, 4'd1);
		send_file(1'b1, bmp4_pkg::SIGNATURE, 32'd30, 32'd6, 32'd2, bmp4_pkg::DEPTH_4BPP, 30,
			body_len(30, 6, 2));

		nfile = 0;
		while (bytes_sent < ITEMS) begin
			nfile++;
			if (nfile % 2 == 0)
				reconfigure(16'($urandom), 16'($urandom), 4'($urandom_range(15)));
			kind = $urandom_range(99);
			w = ($urandom_range(9) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 17);
			hmag = $urandom_range(1, 4);
			h = $urandom_range(1) ? (~hmag + 32'd1) : hmag;
			off = ($urandom_range(3) == 0) ? $urandom_range(0, 29) : $urandom_range(30, 38);
			sig = bmp4_pkg::SIGNATURE;
			depth = bmp4_pkg::DEPTH_4BPP;
			hdr_len = 30;
			body = body_len(off, w, hmag);
			if ($urandom_range(3) == 0)
				body = body + $urandom_range(1, 4);
			if (kind < 72) begin
				// well-formed
			end else if (kind < 77) begin
				sig = 16'($urandom);
			end else if (kind < 82) begin
				depth = 16'($urandom_range(0, 255));
			end else if (kind < 86) begin
				case ($urandom_range(2))
					0: w = $urandom_range(4097, 9000);
					1: w = 32'h8000_0000 | $urandom;
					default: h = ~($urandom_range(4097, 70000)) + 32'd1;
				endcase
				body = $urandom_range(0, 3);
			end else if (kind < 89) begin
				if ($urandom_range(1))
					w = '0;
				else
					h = '0;
				body = $urandom_range(0, 3);
			end else if (kind < 95) begin
				// cut off by the next start mark
				if ($urandom_range(1)) begin
					hdr_len = $urandom_range(1, 29);
					body = 0;
				end else begin
					body = $urandom_range(0, body - 1);
				end
			end else begin
				sig = 16'($urandom);
				off = $urandom;
				w = $urandom;
				h = $urandom;
				depth = 16'($urandom);
				body = $urandom_range(0, 6);
			end
			send_file(1'b1, sig, off, w, h, depth, hdr_len, body);
		end
		calm = 1'b0;

		drain_results();
		if (sb.pending() != 0) begin
			$display("%0d expected results never arrived", sb.pending());
			sb.mismatches++;
		end
		$display("run covered %0d files, %0d bytes sent, %0d decoded and %0d compared results",
			files_sent, bytes_sent, sb.consumed, sb.checked);
		$display("header errors, empty and oversized images, skips, padding and overrides");
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
